// ===== rtl/core/bam_pkg.sv =====
// Shared constants, codes and types of the bitmap allocation map.
package bam_pkg;

    // Map geometry.
    localparam int MAP_BITS    = 4096;
    localparam int WORD_BITS   = 32;
    localparam int STORE_DEPTH = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW     = $clog2(STORE_DEPTH);
    localparam int BIT_AW      = $clog2(WORD_BITS);

    // Field widths.
    localparam int OP_W    = 3;
    localparam int INDEX_W = 16;
    localparam int LEN_W   = 13;
    localparam int SIZE_W  = 13;
    localparam int END_W   = INDEX_W + 1;

    // Request codes.
    localparam logic [OP_W-1:0] OP_SET_BIT     = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR_BIT   = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE_BIT   = 3'd2;
    localparam logic [OP_W-1:0] OP_TEST_BIT    = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_RANGE   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR_RANGE = 3'd5;

    // Reset value of the map size register.
    localparam logic [SIZE_W-1:0] MAP_BITS_RESET = SIZE_W'(MAP_BITS);

    // What the word unit does to the masked bits.
    typedef enum logic [1:0] {
        ACT_SET   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_TEST  = 2'd2
    } action_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

// ===== rtl/core/bam_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/bam_alu.sv =====
// Word unit: builds the edge mask and sets, clears or tests one map word.
module bam_alu
    import bam_pkg::*;
(
    input  logic [WORD_BITS-1:0] word_in,
    input  logic [BIT_AW-1:0]    lo_bit,
    input  logic [BIT_AW-1:0]    hi_bit,
    input  action_t              action,
    output logic [WORD_BITS-1:0] word_out,
    output logic                 test_bit
);

    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] mask;

    // Bits from lo_bit up to hi_bit inclusive.
    always_comb begin
        lo_mask = {WORD_BITS{1'b1}} << lo_bit;
        hi_mask = {WORD_BITS{1'b1}} >> (BIT_AW'(WORD_BITS - 1) - hi_bit);
        mask    = lo_mask & hi_mask;
    end

    // Apply the action to the masked bits.
    always_comb begin
        test_bit = 1'b0;
        case (action)
            ACT_SET:   word_out = word_in | mask;
            ACT_CLEAR: word_out = word_in & ~mask;
            ACT_TEST: begin
                word_out = word_in;
                test_bit = word_in[lo_bit];
            end
            default:   word_out = word_in;
        endcase
    end

endmodule

// ===== rtl/core/bitmap_allocation_map_unit.sv =====
// Top level of the bitmap allocation map: request decode, word sequencer, store.
// Flow: a request is taken only in idle; a bit or range request with work walks its store words,
// one per cycle, and loads its result at its last word; a flagged, empty or unused-code request
// loads its result straight from idle. A result that cannot yet be loaded waits in the done state.
// Throughput: one request at a time, taken again once its result is loaded.
// Reset: synchronous, active low; clears the per-word valid flags (no clearing pass).
module bitmap_allocation_map_unit
    import bam_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Input words.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,  // index[15:0], bit_value_in[16],
                                          // range_length[29:17], zero[31:30]
    input  logic [OP_W-1:0]     s_tuser,  // operation[2:0]
    // Result words.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,  // status[0], bit_value_out[1], zero[7:2]
    // Map size register.
    input  logic                cfg_we,
    input  logic [SIZE_W-1:0]   cfg_wdata
);

    // Request fields.
    logic [OP_W-1:0]    in_op;
    logic [INDEX_W-1:0] in_index;
    logic               in_value;
    logic [LEN_W-1:0]   in_len;

    // Decode results.
    logic [SIZE_W-1:0]  size_eff;
    logic [END_W-1:0]   end_sum;
    logic [END_W-1:0]   end_m1;
    logic               dec_err;
    logic               dec_work;
    logic [WORD_AW-1:0] dec_first;
    logic [WORD_AW-1:0] dec_last;
    logic [BIT_AW-1:0]  dec_lo;
    logic [BIT_AW-1:0]  dec_hi;
    action_t            dec_action;

    // Control and request registers.
    state_t             state_reg, state_next;
    logic [SIZE_W-1:0]  map_bits_reg, map_bits_next;
    logic [WORD_AW-1:0] cur_word_reg, cur_word_next;
    logic [WORD_AW-1:0] first_word_reg, first_word_next;
    logic [WORD_AW-1:0] last_word_reg, last_word_next;
    logic [BIT_AW-1:0]  lo_bit_reg, lo_bit_next;
    logic [BIT_AW-1:0]  hi_bit_reg, hi_bit_next;
    action_t            action_reg, action_next;
    logic               status_reg, status_next;
    logic               bit_reg, bit_next;
    logic [STORE_DEPTH-1:0] valid_reg, valid_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               m_status_reg, m_status_next;
    logic               m_bit_reg, m_bit_next;

    // Store and word unit signals.
    logic                 accept;
    logic                 out_free;
    logic                 result_load;
    logic                 is_last;
    logic [WORD_AW-1:0]   rd_addr;
    logic [WORD_BITS-1:0] ram_q;
    logic [WORD_BITS-1:0] word_cur;
    logic [WORD_BITS-1:0] word_new;
    logic [BIT_AW-1:0]    alu_lo;
    logic [BIT_AW-1:0]    alu_hi;
    logic                 alu_test;
    logic                 wr_en;

    assign in_index = s_tdata[15:0];
    assign in_value = s_tdata[16];
    assign in_len   = s_tdata[29:17];
    assign in_op    = s_tuser;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_last  = (cur_word_reg == last_word_reg);

    // Size in effect and range end.
    always_comb begin
        size_eff = (map_bits_reg > SIZE_W'(MAP_BITS)) ? SIZE_W'(MAP_BITS) : map_bits_reg;
        end_sum  = END_W'(in_index) + END_W'(in_len);
        end_m1   = end_sum - END_W'(1);
    end

    // Request decode.
    always_comb begin
        dec_err    = 1'b0;
        dec_work   = 1'b0;
        dec_first  = in_index[BIT_AW +: WORD_AW];
        dec_last   = in_index[BIT_AW +: WORD_AW];
        dec_lo     = in_index[BIT_AW-1:0];
        dec_hi     = in_index[BIT_AW-1:0];
        dec_action = ACT_TEST;
        case (in_op) inside
            OP_SET_BIT, OP_CLEAR_BIT, OP_WRITE_BIT, OP_TEST_BIT: begin
                dec_err  = (in_index >= INDEX_W'(size_eff));
                dec_work = !dec_err;
                if (in_op == OP_SET_BIT || (in_op == OP_WRITE_BIT && in_value)) begin
                    dec_action = ACT_SET;
                end else if (in_op == OP_TEST_BIT) begin
                    dec_action = ACT_TEST;
                end else begin
                    dec_action = ACT_CLEAR;
                end
            end
            OP_SET_RANGE, OP_CLEAR_RANGE: begin
                dec_err    = (end_sum > END_W'(size_eff));
                dec_work   = !dec_err && (in_len != '0);
                dec_last   = end_m1[BIT_AW +: WORD_AW];
                dec_hi     = end_m1[BIT_AW-1:0];
                dec_action = (in_op == OP_SET_RANGE) ? ACT_SET : ACT_CLEAR;
            end
            default: begin
                dec_err  = 1'b0;
                dec_work = 1'b0;
            end
        endcase
    end

    // Word unit operands: edge words are masked, inner words are whole.
    always_comb begin
        word_cur = rd_valid_reg ? ram_q : '0;
        alu_lo   = (cur_word_reg == first_word_reg) ? lo_bit_reg : '0;
        alu_hi   = is_last ? hi_bit_reg : BIT_AW'(WORD_BITS - 1);
        wr_en    = (state_reg == ST_WALK) && (action_reg != ACT_TEST);
        rd_addr  = (state_reg == ST_WALK) ? (cur_word_reg + WORD_AW'(1)) : dec_first;
    end

    bam_alu u_alu (
        .word_in  (word_cur),
        .lo_bit   (alu_lo),
        .hi_bit   (alu_hi),
        .action   (action_reg),
        .word_out (word_new),
        .test_bit (alu_test)
    );

    bam_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (cur_word_reg),
        .wr_data (word_new),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Sequencer and result register.
    always_comb begin
        state_next      = state_reg;
        map_bits_next   = cfg_we ? cfg_wdata : map_bits_reg;
        cur_word_next   = cur_word_reg;
        first_word_next = first_word_reg;
        last_word_next  = last_word_reg;
        lo_bit_next     = lo_bit_reg;
        hi_bit_next     = hi_bit_reg;
        action_next     = action_reg;
        status_next     = status_reg;
        bit_next        = bit_reg;
        valid_next      = valid_reg;
        rd_valid_next   = valid_reg[rd_addr];
        m_status_next   = m_status_reg;
        m_bit_next      = m_bit_reg;
        result_load     = 1'b0;

        if (wr_en) begin
            valid_next[cur_word_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cur_word_next   = dec_first;
                    first_word_next = dec_first;
                    last_word_next  = dec_last;
                    lo_bit_next     = dec_lo;
                    hi_bit_next     = dec_hi;
                    action_next     = dec_action;
                    status_next     = dec_err;
                    bit_next        = 1'b0;
                    if (dec_work) begin
                        state_next = ST_WALK;
                    end else if (out_free) begin
                        result_load   = 1'b1;
                        m_status_next = dec_err;
                        m_bit_next    = 1'b0;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WALK: begin
                if (is_last) begin
                    bit_next = (action_reg == ACT_TEST) && alu_test;
                    if (out_free) begin
                        result_load   = 1'b1;
                        m_status_next = 1'b0;
                        m_bit_next    = (action_reg == ACT_TEST) && alu_test;
                        state_next    = ST_IDLE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    cur_word_next = cur_word_reg + WORD_AW'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    result_load   = 1'b1;
                    m_status_next = status_reg;
                    m_bit_next    = bit_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (result_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            map_bits_reg <= MAP_BITS_RESET;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            map_bits_reg <= map_bits_next;
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cur_word_reg   <= cur_word_next;
        first_word_reg <= first_word_next;
        last_word_reg  <= last_word_next;
        lo_bit_reg     <= lo_bit_next;
        hi_bit_reg     <= hi_bit_next;
        action_reg     <= action_next;
        status_reg     <= status_next;
        bit_reg        <= bit_next;
        m_status_reg   <= m_status_next;
        m_bit_reg      <= m_bit_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_bit_reg, m_status_reg};

    // The store is written only while a request walks its words.
    a_write_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_WALK))
        else $error("store written outside a walk");

    // A walk never runs past its last word.
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (cur_word_reg <= last_word_reg))
        else $error("walk passed its last word");

    // A result is loaded only when the result register can take it.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        result_load |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten");

    // A flagged request never touches the store.
    a_err_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && dec_err) |=> !wr_en)
        else $error("flagged request wrote the store");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the bitmap allocation map unit with a built-in map predictor.
module tb_top
    import bam_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes that the block treats as no-ops.
    localparam logic [OP_W-1:0] OP_RESERVED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_RESERVED_B = 3'd7;

    // A range walk touches at most one word per cycle, plus a little margin.
    localparam int DRAIN_CYCLES = STORE_DEPTH + 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        bit status;
        bit tested;
    } alloc_result_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [31:0]         s_tdata;   // index[15:0], bit_value_in[16], range_length[29:17]
    logic [OP_W-1:0]     s_tuser;   // operation[2:0]
    logic                m_tvalid;
    logic                m_tready;
    logic [7:0]          m_tdata;   // status[0], bit_value_out[1]
    logic                cfg_we;
    logic [SIZE_W-1:0]   cfg_wdata;

    // Predictor state: one bit per map unit and the size register.
    bit [MAP_BITS-1:0]   map_image;
    logic [SIZE_W-1:0]   map_size_reg;
    alloc_result_t       pending_alloc_results[$];

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off_req;

    int words_sent;
    int range_words;
    int results_checked;
    int flagged_results;
    int sizes_written;
    int failures;

    bitmap_allocation_map_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Size of the map in effect: an oversized register acts as the full map.
    function automatic int unsigned effective_size();
        return (map_size_reg > MAP_BITS) ? MAP_BITS : map_size_reg;
    endfunction

    // Apply one request to the map image and work out its result word.
    function automatic alloc_result_t apply_alloc_request(input logic [OP_W-1:0] op,
                                                          input logic [15:0] idx,
                                                          input bit val,
                                                          input logic [12:0] len);
        alloc_result_t res;
        int unsigned size_eff;
        int unsigned stop;
        size_eff = effective_size();
        res = '0;
        case (op) inside
            OP_SET_BIT, OP_CLEAR_BIT, OP_WRITE_BIT, OP_TEST_BIT: begin
                if (idx >= size_eff) begin
                    res.status = 1'b1;
                end else if (op == OP_SET_BIT) begin
                    map_image[idx] = 1'b1;
                end else if (op == OP_CLEAR_BIT) begin
                    map_image[idx] = 1'b0;
                end else if (op == OP_WRITE_BIT) begin
                    map_image[idx] = val;
                end else begin
                    res.tested = map_image[idx];
                end
            end
            OP_SET_RANGE, OP_CLEAR_RANGE: begin
                stop = idx + len;
                if (stop > size_eff) begin
                    res.status = 1'b1;
                end else begin
                    for (int unsigned b = idx; b < stop; b++)
                        map_image[b] = (op == OP_SET_RANGE);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offer one word, with random idle gaps, and record its expected result on acceptance.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [15:0] idx,
                                input bit val, input logic [12:0] len);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, len, val, idx};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        pending_alloc_results.push_back(apply_alloc_request(op, idx, val, len));
        words_sent++;
        if (op == OP_SET_RANGE || op == OP_CLEAR_RANGE)
            range_words++;
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_map_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_alloc_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_map_size(input logic [SIZE_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        map_size_reg = value;
        sizes_written++;
    endtask

    // Random request, mostly well inside the map, with some out-of-range noise.
    task automatic send_random_request();
        logic [OP_W-1:0] op;
        logic [15:0] idx;
        logic [12:0] len;
        bit val;
        int unsigned size_eff;
        int unsigned roll;
        int unsigned pick;
        size_eff = effective_size();
        roll = $urandom_range(99);
        pick = $urandom_range(99);
        val  = 1'($urandom_range(1));
        len  = 13'($urandom_range(13'h1FFF));
        if (roll < 62) begin
            op = OP_W'($urandom_range(OP_TEST_BIT));
            if (pick < 85)
                idx = (size_eff != 0) ? 16'($urandom_range(size_eff - 1)) : 16'd0;
            else if (pick < 93)
                idx = 16'(size_eff);
            else
                idx = 16'($urandom_range(16'hFFFF));
        end else if (roll < 95) begin
            op = $urandom_range(1) ? OP_SET_RANGE : OP_CLEAR_RANGE;
            idx = (pick < 90) ? 16'($urandom_range(size_eff))
                              : 16'($urandom_range(16'hFFFF));
            pick = $urandom_range(99);
            if (pick < 85)
                len = 13'($urandom_range(40));
            else if (pick < 93)
                len = (idx <= size_eff) ? 13'(size_eff - idx) : 13'd0;
            else if (pick < 98)
                len = 13'($urandom_range(MAP_BITS));
        end else begin
            op  = $urandom_range(1) ? OP_RESERVED_A : OP_RESERVED_B;
            idx = 16'($urandom_range(16'hFFFF));
        end
        send_request(op, idx, val, len);
    endtask

    // Extremes of the fields, every operation and the edge cases at the full map size.
    task automatic run_directed_checks();
        send_request(OP_SET_BIT,     16'd0,     1'b0, 13'd0);
        send_request(OP_TEST_BIT,    16'd0,     1'b0, 13'd0);
        send_request(OP_SET_BIT,     16'd4095,  1'b0, 13'd0);
        send_request(OP_TEST_BIT,    16'd4095,  1'b0, 13'd0);
        send_request(OP_TEST_BIT,    16'd4096,  1'b0, 13'd0);
        send_request(OP_SET_BIT,     16'hFFFF,  1'b1, 13'h1FFF);
        send_request(OP_CLEAR_BIT,   16'd0,     1'b0, 13'd0);
        send_request(OP_TEST_BIT,    16'd0,     1'b0, 13'd0);
        send_request(OP_WRITE_BIT,   16'd5,     1'b1, 13'd0);
        send_request(OP_TEST_BIT,    16'd5,     1'b0, 13'd0);
        send_request(OP_WRITE_BIT,   16'd5,     1'b0, 13'd0);
        send_request(OP_TEST_BIT,    16'd5,     1'b0, 13'd0);
        // A short range across a word boundary, then a partial clear inside it.
        send_request(OP_SET_RANGE,   16'd30,    1'b0, 13'd5);
        send_request(OP_TEST_BIT,    16'd29,    1'b0, 13'd0);
        send_request(OP_TEST_BIT,    16'd34,    1'b0, 13'd0);
        send_request(OP_TEST_BIT,    16'd35,    1'b0, 13'd0);
        send_request(OP_CLEAR_RANGE, 16'd31,    1'b0, 13'd3);
        send_request(OP_TEST_BIT,    16'd33,    1'b0, 13'd0);
        // A zero length changes nothing.
        send_request(OP_SET_RANGE,   16'd100,   1'b0, 13'd0);
        send_request(OP_TEST_BIT,    16'd100,   1'b0, 13'd0);
        // One past the end is flagged; ending exactly at the end is not.
        send_request(OP_SET_RANGE,   16'd4000,  1'b0, 13'd97);
        send_request(OP_SET_RANGE,   16'd4000,  1'b0, 13'd96);
        send_request(OP_CLEAR_RANGE, 16'd0,     1'b0, 13'd4096);
        send_request(OP_TEST_BIT,    16'd4050,  1'b0, 13'd0);
        send_request(OP_RESERVED_A,  16'hFFFF,  1'b1, 13'h1FFF);
        send_request(OP_RESERVED_B,  16'd0,     1'b0, 13'd0);
        wait_map_idle();
    endtask

    task automatic run_random_traffic(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_random_request();
        wait_map_idle();
    endtask

    // Hold results off for a long stretch while single-bit requests keep coming.
    task automatic run_result_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req = 1'b1;
        for (int k = 0; k < 40; k++)
            send_request(k[0] ? OP_TEST_BIT : OP_SET_BIT, 16'(k * 37), 1'b0, 13'd0);
        wait_map_idle();
    endtask

    // Walk through map sizes, the extremes among them, probing each boundary.
    task automatic run_map_size_sweep();
        logic [SIZE_W-1:0] sizes[7];
        int unsigned size_eff;
        sizes = '{13'd0, 13'd1, 13'h1FFF, 13'd4095, 13'd100, 13'd33, 13'd4096};
        send_idle_pct = 20;
        recv_idle_pct = 20;
        foreach (sizes[i]) begin
            write_map_size(sizes[i]);
            size_eff = effective_size();
            if (size_eff != 0)
                send_request(OP_TEST_BIT, 16'(size_eff - 1), 1'b0, 13'd0);
            send_request(OP_SET_BIT, 16'(size_eff), 1'b0, 13'd0);
            send_request(OP_SET_RANGE, 16'd0, 1'b0, 13'(size_eff));
            repeat (12) send_random_request();
            wait_map_idle();
        end
    endtask

    // Result ready, with random stalls and an occasional long counted hold-off.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input alloc_result_t exp_r);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s: expected status=%0d bit=%0d, got status=%0d bit=%0d",
                     $realtime, what, exp_r.status, exp_r.tested, m_tdata[0], m_tdata[1]);
    endtask

    // Compare every accepted result word with the oldest outstanding expectation.
    always @(posedge aclk) begin : result_check
        alloc_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (pending_alloc_results.size() == 0) begin
                report_mismatch("result with nothing outstanding", '0);
            end else begin
                exp_r = pending_alloc_results.pop_front();
                if (exp_r.status)
                    flagged_results++;
                if (m_tdata[0] !== exp_r.status)
                    report_mismatch("status", exp_r);
                else if (m_tdata[1] !== exp_r.tested)
                    report_mismatch("bit_value_out", exp_r);
            end
        end
    end

    // Main sequence.
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        map_image = '0;
        map_size_reg  = MAP_BITS_RESET;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req  = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        run_directed_checks();
        run_random_traffic(200, 11, 82);
        run_random_traffic(200, 82, 11);
        run_random_traffic(200, 0, 0);
        run_result_backpressure();
        run_map_size_sweep();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_alloc_results.size() != 0) begin
            failures++;
            $display("%0d expected results never arrived", pending_alloc_results.size());
        end
        $display("Covered %0d request words (%0d range requests) over %0d map sizes;",
                 words_sent, range_words, sizes_written);
        $display("%0d results checked, %0d flagged out of range, %0d mismatches.",
                 results_checked, flagged_results, failures);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #10ms;
        $display("Timeout with %0d results outstanding", pending_alloc_results.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
